### rtl/core/lsf_pkg.sv
// Shared types, request codes and bit encoding for the LED strip SPI frame encoder.
package lsf_pkg;

  // Request codes
  localparam logic [1:0] REQ_SET_ONE = 2'd0;
  localparam logic [1:0] REQ_SET_ALL = 2'd1;
  localparam logic [1:0] REQ_SHOW    = 2'd2;
  localparam logic [1:0] REQ_TICK    = 2'd3;

  // Line symbols for one data bit
  localparam logic [2:0] SYM_ONE  = 3'b110;
  localparam logic [2:0] SYM_ZERO = 3'b100;

  localparam logic [7:0] BRIGHT_RESET = 8'd255;
  localparam logic [7:0] LATCH_BYTE   = 8'h00;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } lsf_req_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       frame_last;
  } lsf_res_t;

  // Expand each data bit, MSB first, into a three-bit symbol
  function automatic logic [23:0] encode_byte(input logic [7:0] v);
    logic [23:0] w;
    w = '0;
    for (int b = 7; b >= 0; b--) begin
      w = {w[20:0], (v[b] ? SYM_ONE : SYM_ZERO)};
    end
    return w;
  endfunction

endpackage

### rtl/core/lsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lsf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/lsf_encoder.sv
// Colour scaler and bit encoder: registered multiply, then divide by 255 and expand.
module lsf_encoder
  import lsf_pkg::*;
(
  input  logic        clk,
  input  logic [7:0]  colour,
  input  logic [7:0]  brightness,
  output logic [23:0] word
);

  logic [15:0] product;
  logic [16:0] quot_sum;
  logic [7:0]  scaled;

  // Register the product
  always_ff @(posedge clk) begin
    product <= colour * brightness;
  end

  // Divide by 255: exact for products up to 255*255
  assign quot_sum = 17'(product) + 17'd1 + 17'(product[15:8]);
  assign scaled   = quot_sum[15:8];
  assign word     = encode_byte(scaled);

endmodule

### rtl/core/led_strip_spi_frame_encoder_top.sv
// Top level: frame store, command sequencer and SPI byte output.
//
//   channel  handshake            payload      direction
//   req      start / busy         lsf_req_t    in
//   res      res_valid (strobe)   lsf_res_t    out
//   cfg      cfg_valid/cfg_ready  cfg_data[7:0] in (brightness)
//
// After reset a clearing pass writes zero to every pixel, with busy high.
// Set-all is accepted, then writes one pixel per cycle with busy high. A tick
// on the first byte of a colour steps through acceptance, multiply, then
// divide and encode; the result strobe comes in the cycle after that. Other
// ticks, set-one and show finish at acceptance; a tick's result strobes the
// cycle after its acceptance. The receiver cannot stall; results are never held.
module led_strip_spi_frame_encoder_top
  import lsf_pkg::*;
#(
  parameter int STRIP_LENGTH = 64,
  parameter int LATCH_BYTES  = 100
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  lsf_req_t   req,
  output logic       res_valid,
  output lsf_res_t   res,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int AW = (STRIP_LENGTH > 1) ? $clog2(STRIP_LENGTH) : 1;
  localparam int LW = (LATCH_BYTES > 1) ? $clog2(LATCH_BYTES) : 1;
  localparam logic [AW-1:0] PIX_LAST   = AW'(STRIP_LENGTH - 1);
  localparam logic [LW-1:0] LATCH_LAST = LW'(LATCH_BYTES - 1);
  localparam logic [12:0]   STRIP_LEN  = 13'(STRIP_LENGTH);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_EMIT
  } state_t;

  state_t        state;
  logic [7:0]    brightness;
  logic          sending;
  logic          in_latch;
  logic [AW-1:0] pixel_counter;
  logic [1:0]    colour_phase;
  logic [1:0]    byte_phase;
  logic [LW-1:0] latch_counter;
  logic [AW-1:0] fill_addr;
  logic [23:0]   fill_colour;
  logic [23:0]   encoded_word;

  logic          accept;
  logic          set_one_hit;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [23:0]   mem_wdata;
  logic [23:0]   mem_rdata;
  logic [7:0]    colour_sel;
  logic [23:0]   enc_word;
  logic          pix_wrap;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign set_one_hit = accept && !sending && (req.req_type == REQ_SET_ONE) &&
                       ({1'b0, req.pixel_index} < STRIP_LEN);

  // Store write port: clearing pass, set-all sweep, or one pixel
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill_addr;
    mem_wdata = '0;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == ST_FILL) begin
      mem_we    = 1'b1;
      mem_wdata = fill_colour;
    end else if (set_one_hit) begin
      mem_we    = 1'b1;
      mem_waddr = req.pixel_index[AW-1:0];
      mem_wdata = {req.red, req.green, req.blue};
    end
  end

  lsf_ram #(
    .WIDTH(24),
    .DEPTH(STRIP_LENGTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (pixel_counter),
    .rdata (mem_rdata)
  );

  // Pick the colour for this phase: green, red, blue
  always_comb begin
    case (colour_phase)
      2'd0:    colour_sel = mem_rdata[15:8];
      2'd1:    colour_sel = mem_rdata[23:16];
      default: colour_sel = mem_rdata[7:0];
    endcase
  end

  lsf_encoder u_encoder (
    .clk        (clk),
    .colour     (colour_sel),
    .brightness (brightness),
    .word       (enc_word)
  );

  assign pix_wrap = (byte_phase == 2'd2) && (colour_phase == 2'd2) &&
                    (pixel_counter == PIX_LAST);

  // Hold brightness
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= BRIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      brightness <= cfg_data;
    end
  end

  // Sequencer, frame counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      sending       <= 1'b0;
      in_latch      <= 1'b0;
      pixel_counter <= '0;
      colour_phase  <= '0;
      byte_phase    <= '0;
      latch_counter <= '0;
      fill_addr     <= '0;
      res_valid     <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      case (state)
        ST_CLEAR, ST_FILL: begin
          if (fill_addr == PIX_LAST) begin
            fill_addr <= '0;
            state     <= ST_IDLE;
          end else begin
            fill_addr <= fill_addr + AW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (req.req_type != REQ_TICK) begin
              if (!sending) begin
                if (req.req_type == REQ_SET_ALL) begin
                  fill_colour <= {req.red, req.green, req.blue};
                  fill_addr   <= '0;
                  state       <= ST_FILL;
                end else if (req.req_type == REQ_SHOW) begin
                  sending       <= 1'b1;
                  in_latch      <= 1'b0;
                  pixel_counter <= '0;
                  colour_phase  <= '0;
                  byte_phase    <= '0;
                  latch_counter <= '0;
                end
              end
            end else if (sending) begin
              if (in_latch) begin
                // Emit a latch byte
                res_valid      <= 1'b1;
                res.spi_byte   <= LATCH_BYTE;
                res.frame_last <= (latch_counter == LATCH_LAST);
                if (latch_counter == LATCH_LAST) begin
                  latch_counter <= '0;
                  in_latch      <= 1'b0;
                  sending       <= 1'b0;
                end else begin
                  latch_counter <= latch_counter + LW'(1);
                end
              end else if (byte_phase == 2'd0) begin
                state <= ST_READ;
              end else begin
                // Emit a later byte of the held word
                res_valid      <= 1'b1;
                res.spi_byte   <= (byte_phase == 2'd1) ? encoded_word[15:8]
                                                       : encoded_word[7:0];
                res.frame_last <= 1'b0;
                if (byte_phase == 2'd2) begin
                  byte_phase <= 2'd0;
                  if (colour_phase == 2'd2) begin
                    colour_phase <= 2'd0;
                    if (pix_wrap) begin
                      pixel_counter <= '0;
                      in_latch      <= 1'b1;
                      latch_counter <= '0;
                    end else begin
                      pixel_counter <= pixel_counter + AW'(1);
                    end
                  end else begin
                    colour_phase <= colour_phase + 2'd1;
                  end
                end else begin
                  byte_phase <= byte_phase + 2'd1;
                end
              end
            end
          end
        end
        ST_READ: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          // Emit the first byte of a freshly encoded colour
          encoded_word   <= enc_word;
          res_valid      <= 1'b1;
          res.spi_byte   <= enc_word[23:16];
          res.frame_last <= 1'b0;
          byte_phase     <= 2'd1;
          state          <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
